### rtl/mftp_pkg.sv
package mftp_pkg;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_DELTA      = 8'b0000_0001,
        PH_STATUS     = 8'b0000_0010,
        PH_CHAN_DATA  = 8'b0000_0100,
        PH_SYSEX_LEN  = 8'b0000_1000,
        PH_SYSEX_DATA = 8'b0001_0000,
        PH_META_TYPE  = 8'b0010_0000,
        PH_META_LEN   = 8'b0100_0000,
        PH_META_DATA  = 8'b1000_0000
    } phase_t;

    localparam logic [3:0] KIND_SYSTEM  = 4'd7;
    localparam logic [3:0] KIND_TEMPO   = 4'd8;
    localparam logic [3:0] KIND_TIMESIG = 4'd9;
    localparam logic [3:0] KIND_META    = 4'd10;
    localparam logic [3:0] KIND_EOT     = 4'd11;
    localparam logic [3:0] KIND_ERROR   = 4'd12;

    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_ESCAPE   = 8'hF7;
    localparam logic [7:0] ST_META     = 8'hFF;
    localparam logic [7:0] META_SEQ    = 8'h00;
    localparam logic [7:0] META_CHPFX  = 8'h20;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_SMPTE  = 8'h54;
    localparam logic [7:0] META_TSIG   = 8'h58;
    localparam logic [7:0] META_KSIG   = 8'h59;

    localparam logic [23:0] TEMPO_RESET = 24'd500000;
    localparam int          QW          = 28;

    // One result beat, packed as on the output tdata.
    typedef struct packed {
        logic        track_end;
        logic [31:0] event_tick;
        logic [7:0]  beat_unit_log2;
        logic [7:0]  beats_per_bar;
        logic [23:0] tempo_us;
        logic [13:0] second_value;
        logic [6:0]  first_data;
        logic [3:0]  channel;
        logic [3:0]  kind;
    } result_t;

    // Byte stage to parser: classified byte.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } fbyte_t;

    // Number of data bytes that follow a short-message status.
    function automatic logic [1:0] data_length(input logic [7:0] st);
        logic [3:0] ev;
        ev = st[7:4];
        if (st == 8'hF3 || ev == 4'hC || ev == 4'hD)
            return 2'd1;
        if (st == 8'hF1 || (st >= 8'hF4 && st <= 8'hF6) || (st >= 8'hF8 && st <= 8'hFE))
            return 2'd0;
        return 2'd2;
    endfunction

endpackage

### rtl/mftp_front.sv
module mftp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            in_byte,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           track_length,
    input  logic                  halt,
    output mftp_pkg::fbyte_t      q_data,
    output logic                  q_valid,
    input  logic                  q_ready
);
    import mftp_pkg::*;

    logic [31:0] consumed_reg;
    logic        take;
    logic        pass;
    fbyte_t      hold_reg;
    logic        hold_valid_reg;

    // Bytes past the track end or after an error are dropped here.
    assign in_ready = !hold_valid_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign pass     = take && !halt && (consumed_reg < track_length);
    assign q_data   = hold_reg;
    assign q_valid  = hold_valid_reg;

    // Byte counter and one-entry queue toward the parser.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumed_reg   <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (pass)
                consumed_reg <= consumed_reg + 32'd1;
            if (in_ready)
                hold_valid_reg <= pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && pass)
        begin
            hold_reg.data <= in_byte;
            hold_reg.last <= (consumed_reg + 32'd1 == track_length);
        end
    end

endmodule

### rtl/mftp_parser.sv
module mftp_parser #(
    parameter int MAX_QUANTITY_BYTES     = 4,
    parameter int CAPTURED_PAYLOAD_BYTES = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mftp_pkg::fbyte_t      q_data,
    input  logic                  q_valid,
    output logic                  q_ready,
    output logic                  halt,
    output mftp_pkg::result_t     res_data,
    output logic                  res_valid,
    input  logic                  res_ready
);
    import mftp_pkg::*;

    localparam int QCW = $clog2(MAX_QUANTITY_BYTES + 1);
    localparam int CIW = $clog2(CAPTURED_PAYLOAD_BYTES);

    phase_t             phase_reg, phase_next;
    logic [QW-1:0]      qacc_reg, qacc_next;
    logic [QCW-1:0]     qcnt_reg, qcnt_next;
    logic [7:0]         rs_reg, rs_next;
    logic [7:0]         cs_reg, cs_next;
    logic [7:0]         mt_reg, mt_next;
    logic [QW-1:0]      rem_reg, rem_next;
    logic [QW-1:0]      plen_reg, plen_next;
    logic [7:0]         cap_reg [CAPTURED_PAYLOAD_BYTES];
    logic [7:0]         cap_next [CAPTURED_PAYLOAD_BYTES];
    logic [7:0]         lpb_reg, lpb_next;
    logic [31:0]        tick_reg, tick_next;
    logic [23:0]        tempo_reg, tempo_next;
    logic [7:0]         num_reg, num_next;
    logic [7:0]         den_reg, den_next;
    logic               err_reg, err_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg;
    logic               emit;

    logic [7:0]         b;
    logic               last;
    logic               step;
    logic               q_over;
    logic               q_done;
    logic [QW-1:0]      q_acc;
    logic [7:0]         st;
    logic [1:0]         dlen;
    logic [QW-1:0]      rem_dec;
    logic [QW-1:0]      midx;
    logic               fin_short, fin_sysex, fin_meta, bad;
    logic               meta_ok;
    logic [3:0]         meta_kind;
    logic [3:0]         ev_kind;
    logic [6:0]         d0, d1;

    // Bytes still queued behind an error are popped and discarded.
    assign b         = q_data.data;
    assign last      = q_data.last;
    assign q_ready   = !out_valid_reg || res_ready;
    assign step      = q_valid && q_ready && !err_reg;
    assign halt      = err_reg;
    assign res_data  = out_reg;
    assign res_valid = out_valid_reg;

    // Shared variable-length quantity step.
    assign q_over  = (qcnt_reg >= QCW'(MAX_QUANTITY_BYTES));
    assign q_acc   = {qacc_reg[QW-8:0], b[6:0]};
    assign q_done  = !b[7];
    assign rem_dec = rem_reg - QW'(1);
    assign midx    = plen_reg - rem_reg;

    // Event decode and update of the parser state.
    always_comb
    begin
        phase_next = phase_reg;
        qacc_next  = qacc_reg;
        qcnt_next  = qcnt_reg;
        rs_next    = rs_reg;
        cs_next    = cs_reg;
        mt_next    = mt_reg;
        rem_next   = rem_reg;
        plen_next  = plen_reg;
        for (int i = 0; i < CAPTURED_PAYLOAD_BYTES; i++)
            cap_next[i] = cap_reg[i];
        lpb_next   = lpb_reg;
        tick_next  = tick_reg;
        tempo_next = tempo_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        err_next   = err_reg;
        fin_short  = 1'b0;
        fin_sysex  = 1'b0;
        fin_meta   = 1'b0;
        bad        = 1'b0;
        st         = (b < 8'h80) ? rs_reg : b;
        dlen       = data_length(st);
        unique case (phase_reg)
            PH_DELTA:
            begin
                if (q_over)
                    bad = 1'b1;
                else
                begin
                    qcnt_next = qcnt_reg + QCW'(1);
                    qacc_next = q_acc;
                    if (q_done)
                    begin
                        tick_next  = tick_reg + 32'(q_acc);
                        phase_next = PH_STATUS;
                    end
                end
            end
            PH_STATUS:
            begin
                if (!st[7])
                    bad = 1'b1;
                else
                begin
                    if (st < ST_SYSEX)
                        rs_next = st;
                    cs_next = st;
                    if (st == ST_SYSEX || st == ST_ESCAPE)
                    begin
                        qacc_next  = '0;
                        qcnt_next  = '0;
                        phase_next = PH_SYSEX_LEN;
                    end
                    else if (st == ST_META)
                        phase_next = PH_META_TYPE;
                    else
                    begin
                        plen_next   = QW'(dlen);
                        cap_next[0] = b[7] ? 8'h00 : b;
                        cap_next[1] = 8'h00;
                        rem_next    = QW'(dlen) - QW'(!b[7]);
                        if (rem_next == '0)
                            fin_short = 1'b1;
                        else
                            phase_next = PH_CHAN_DATA;
                    end
                end
            end
            PH_CHAN_DATA:
            begin
                cap_next[CIW'(midx[0])] = b;
                rem_next = rem_dec;
                if (rem_dec == '0)
                    fin_short = 1'b1;
            end
            PH_SYSEX_LEN, PH_META_LEN:
            begin
                if (q_over)
                    bad = 1'b1;
                else
                begin
                    qcnt_next = qcnt_reg + QCW'(1);
                    qacc_next = q_acc;
                    if (q_done)
                    begin
                        plen_next = q_acc;
                        rem_next  = q_acc;
                        if (phase_reg == PH_SYSEX_LEN)
                        begin
                            lpb_next = 8'h00;
                            if (q_acc == '0)
                                fin_sysex = 1'b1;
                            else
                                phase_next = PH_SYSEX_DATA;
                        end
                        else if (q_acc == '0)
                            fin_meta = 1'b1;
                        else
                            phase_next = PH_META_DATA;
                    end
                end
            end
            PH_SYSEX_DATA:
            begin
                lpb_next = b;
                rem_next = rem_dec;
                if (rem_dec == '0)
                    fin_sysex = 1'b1;
            end
            PH_META_TYPE:
            begin
                mt_next    = b;
                qacc_next  = '0;
                qcnt_next  = '0;
                phase_next = PH_META_LEN;
            end
            PH_META_DATA:
            begin
                if (midx < QW'(CAPTURED_PAYLOAD_BYTES))
                    cap_next[midx[CIW-1:0]] = b;
                rem_next = rem_dec;
                if (rem_dec == '0)
                    fin_meta = 1'b1;
            end
            default:
                bad = 1'b1;
        endcase

        // Meta length checks and kept values.
        meta_ok   = 1'b1;
        meta_kind = KIND_META;
        unique case (mt_reg)
            META_SEQ:    meta_ok = (plen_next == QW'(2));
            META_CHPFX:  meta_ok = (plen_next == QW'(1));
            META_EOT:
            begin
                meta_ok   = (plen_next == '0) && last;
                meta_kind = KIND_EOT;
            end
            META_TEMPO:
            begin
                meta_ok   = (plen_next == QW'(3));
                meta_kind = KIND_TEMPO;
            end
            META_SMPTE:  meta_ok = (plen_next == QW'(5));
            META_TSIG:
            begin
                meta_ok   = (plen_next == QW'(4));
                meta_kind = KIND_TIMESIG;
            end
            META_KSIG:   meta_ok = (plen_next == QW'(2));
            default:     meta_ok = 1'b1;
        endcase
        if (fin_meta && meta_ok)
        begin
            if (mt_reg == META_TEMPO)
                tempo_next = {cap_next[0], cap_next[1], cap_next[2]};
            if (mt_reg == META_TSIG)
            begin
                num_next = cap_next[0];
                den_next = cap_next[1];
            end
        end
        if (fin_meta && !meta_ok)
            bad = 1'b1;
        if (fin_sysex && cs_reg == ST_SYSEX && (plen_next == '0 || lpb_next != ST_ESCAPE))
            bad = 1'b1;

        // Truncated event at the track end.
        if (!fin_short && !fin_sysex && !fin_meta && !bad && last
            && phase_next != PH_STATUS && !(phase_next == PH_DELTA && qcnt_next == '0))
            bad = 1'b1;

        // Finished event returns to the delta phase.
        if (!bad && (fin_short || fin_sysex || fin_meta))
        begin
            qacc_next  = '0;
            qcnt_next  = '0;
            phase_next = PH_DELTA;
        end

        d0      = (plen_next >= QW'(1)) ? cap_next[0][6:0] : 7'd0;
        d1      = (plen_next >= QW'(2)) ? cap_next[1][6:0] : 7'd0;
        ev_kind = (cs_next >= ST_SYSEX) ? KIND_SYSTEM : (cs_next[7:4] - 4'd8);

        out_next                = '0;
        out_next.tempo_us       = tempo_next;
        out_next.beats_per_bar  = num_next;
        out_next.beat_unit_log2 = den_next;
        out_next.event_tick     = tick_next;
        out_next.track_end      = last;
        if (bad)
        begin
            err_next      = 1'b1;
            out_next.kind = KIND_ERROR;
        end
        else if (fin_short)
        begin
            out_next.kind         = ev_kind;
            out_next.channel      = cs_next[3:0];
            out_next.first_data   = d0;
            out_next.second_value = (ev_kind == 4'd6) ? {d1, d0} : {7'd0, d1};
        end
        else if (fin_sysex)
        begin
            out_next.kind    = KIND_SYSTEM;
            out_next.channel = cs_reg[3:0];
        end
        else
        begin
            out_next.kind       = meta_kind;
            out_next.first_data = mt_reg[6:0];
        end
        emit = bad || fin_short || fin_sysex || fin_meta;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DELTA;
            qacc_reg      <= '0;
            qcnt_reg      <= '0;
            rs_reg        <= '0;
            cs_reg        <= '0;
            mt_reg        <= '0;
            rem_reg       <= '0;
            plen_reg      <= '0;
            lpb_reg       <= '0;
            tick_reg      <= '0;
            tempo_reg     <= TEMPO_RESET;
            num_reg       <= 8'd4;
            den_reg       <= 8'd2;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_ready)
                out_valid_reg <= step && emit;
            if (step)
            begin
                phase_reg <= phase_next;
                qacc_reg  <= qacc_next;
                qcnt_reg  <= qcnt_next;
                rs_reg    <= rs_next;
                cs_reg    <= cs_next;
                mt_reg    <= mt_next;
                rem_reg   <= rem_next;
                plen_reg  <= plen_next;
                lpb_reg   <= lpb_next;
                tick_reg  <= tick_next;
                tempo_reg <= tempo_next;
                num_reg   <= num_next;
                den_reg   <= den_next;
                err_reg   <= err_next;
            end
        end
    end

    // Payload capture and output register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < CAPTURED_PAYLOAD_BYTES; i++)
                cap_reg[i] <= cap_next[i];
            if (emit)
                out_reg <= out_next;
        end
    end

endmodule

### rtl/midi_file_track_event_parser.sv
// MIDI file track event parser.
// Feed the data bytes of one track, one per beat, on s_axis (tdata = data_byte).
// Before a track, write its byte count on the cfg channel while the block is idle.
// Each completed event gives one beat on m_axis with its kind, channel, data,
// current tempo and time signature, tick and a track-end flag.
// A result goes through the byte queue stage, then the parser's output register.
// Throughput: one byte per cycle unless m_axis stalls; the parser state
// machine advances once a byte. When m_axis stalls, the result register holds,
// the byte queue fills and then s_axis_tready drops; nothing is lost.
// Bytes beyond the track length are taken and dropped. After an error the
// block gives one error result and then drops all bytes until reset.
// Reset (rst_n low) restores the default tempo (500000 us) and 4/4 time,
// zero ticks, zero track length and no running status.
module midi_file_track_event_parser #(
    parameter int MAX_QUANTITY_BYTES     = 4,
    parameter int CAPTURED_PAYLOAD_BYTES = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [31:0]  cfg_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    // tdata: data_byte[7:0]
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: kind[3:0], channel[7:4], first_data[14:8], second_value[28:15],
    // tempo_us[52:29], beats_per_bar[60:53], beat_unit_log2[68:61],
    // event_tick[100:69], track_end[101], zero fill [103:102]
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready
);
    import mftp_pkg::*;

    logic [31:0] track_length_reg;
    fbyte_t      q_data;
    logic        q_valid;
    logic        q_ready;
    logic        halt;
    result_t     res;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {2'b00, res};

    // Track length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            track_length_reg <= '0;
        else if (cfg_valid)
            track_length_reg <= cfg_data;
    end

    mftp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (s_axis_tdata),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .track_length (track_length_reg),
        .halt         (halt),
        .q_data       (q_data),
        .q_valid      (q_valid),
        .q_ready      (q_ready)
    );

    mftp_parser #(
        .MAX_QUANTITY_BYTES     (MAX_QUANTITY_BYTES),
        .CAPTURED_PAYLOAD_BYTES (CAPTURED_PAYLOAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .halt      (halt),
        .res_data  (res),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready)
    );

endmodule

### verif/tb_midi_file_track_event_parser.sv
`timescale 1ns / 100ps

module tb_midi_file_track_event_parser;
    import mftp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_QBYTES  = 4;
    localparam int CAPTURE_LEN = 5;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [31:0]  cfg_data = '0;
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    wire  [103:0] m_axis_tdata;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles = 0;

    // Number of data bytes that follow a short-message status byte.
    function automatic int short_msg_bytes(logic [7:0] st);
        if (st == 8'hF3 || st[7:4] == 4'hC || st[7:4] == 4'hD)
            return 1;
        if (st == 8'hF1 || (st >= 8'hF4 && st <= 8'hF6) || (st >= 8'hF8 && st <= 8'hFE))
            return 0;
        return 2;
    endfunction

    // Track parser prediction and the queue of events still to arrive.
    class track_scoreboard;
        logic [31:0] track_length;
        logic [31:0] consumed;
        logic [31:0] ticks;
        phase_t      phase;
        logic [27:0] acc;
        logic [27:0] plen;
        logic [27:0] remain;
        int          qcount;
        logic [7:0]  running;
        logic [7:0]  cur;
        logic [7:0]  mtype;
        logic [7:0]  last_pb;
        logic [7:0]  cap [CAPTURE_LEN];
        logic [23:0] tempo;
        logic [7:0]  numer;
        logic [7:0]  denom_exp;
        bit          err_latched;
        result_t     expected_q [$];
        int          errors;

        function new();
            track_length = '0;
            consumed = '0;
            ticks = '0;
            phase = PH_DELTA;
            acc = '0;
            plen = '0;
            remain = '0;
            qcount = 0;
            running = '0;
            cur = '0;
            mtype = '0;
            last_pb = '0;
            foreach (cap[i])
                cap[i] = '0;
            tempo = TEMPO_RESET;
            numer = 8'd4;
            denom_exp = 8'd2;
            err_latched = 1'b0;
            errors = 0;
        endfunction

        function void restart(phase_t p);
            acc = '0;
            qcount = 0;
            phase = p;
        endfunction

        // Returns -1 when the quantity runs too long, 0 for more, 1 when done.
        function int take_quantity(logic [7:0] b);
            if (qcount >= MAX_QBYTES)
                return -1;
            qcount++;
            acc = {acc[20:0], b[6:0]};
            return b[7] ? 0 : 1;
        endfunction

        function result_t make_result(logic [3:0] kind, logic [3:0] ch, logic [6:0] fd,
                                      logic [13:0] sv, bit last);
            result_t r;
            r.kind = kind;
            r.channel = ch;
            r.first_data = fd;
            r.second_value = sv;
            r.tempo_us = tempo;
            r.beats_per_bar = numer;
            r.beat_unit_log2 = denom_exp;
            r.event_tick = ticks;
            r.track_end = last;
            return r;
        endfunction

        function bit close_short(bit last, output result_t r);
            logic [6:0] d0;
            logic [6:0] d1;
            logic [3:0] kind;
            d0 = (plen >= 1) ? cap[0][6:0] : 7'd0;
            d1 = (plen >= 2) ? cap[1][6:0] : 7'd0;
            kind = (cur >= 8'hF0) ? KIND_SYSTEM : cur[7:4] - 4'd8;
            restart(PH_DELTA);
            r = make_result(kind, cur[3:0], d0, (kind == 4'd6) ? {d1, d0} : {7'd0, d1}, last);
            return 1'b1;
        endfunction

        function bit close_meta(bit last, output result_t r);
            logic [3:0] kind;
            bit ok;
            kind = KIND_META;
            ok = 1'b1;
            case (mtype)
                META_SEQ:   ok = (plen == 2);
                META_CHPFX: ok = (plen == 1);
                META_EOT:
                begin
                    ok = (plen == 0) && last;
                    kind = KIND_EOT;
                end
                META_TEMPO:
                begin
                    ok = (plen == 3);
                    if (ok)
                        tempo = {cap[0], cap[1], cap[2]};
                    kind = KIND_TEMPO;
                end
                META_SMPTE: ok = (plen == 5);
                META_TSIG:
                begin
                    ok = (plen == 4);
                    if (ok)
                    begin
                        numer = cap[0];
                        denom_exp = cap[1];
                    end
                    kind = KIND_TIMESIG;
                end
                META_KSIG:  ok = (plen == 2);
                default:    ok = 1'b1;
            endcase
            if (!ok)
                return 1'b0;
            restart(PH_DELTA);
            r = make_result(kind, 4'd0, mtype[6:0], 14'd0, last);
            return 1'b1;
        endfunction

        function bit close_sysex(bit last, output result_t r);
            if (cur == ST_SYSEX && (plen == 0 || last_pb != ST_ESCAPE))
                return 1'b0;
            restart(PH_DELTA);
            r = make_result(KIND_SYSTEM, cur[3:0], 7'd0, 14'd0, last);
            return 1'b1;
        endfunction

        // Advance the parser by one accepted track byte.
        function void note_byte(logic [7:0] b);
            logic [7:0] st;
            int q;
            int idx;
            bit last;
            bit fail;
            bit done;
            result_t r;
            if (err_latched || consumed >= track_length)
                return;
            consumed++;
            last = (consumed == track_length);
            fail = 1'b0;
            done = 1'b0;
            case (phase)
                PH_DELTA:
                begin
                    q = take_quantity(b);
                    if (q < 0)
                        fail = 1'b1;
                    else if (q > 0)
                    begin
                        ticks += {4'd0, acc};
                        phase = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    st = b[7] ? b : running;
                    if (!st[7])
                        fail = 1'b1;
                    else
                    begin
                        if (st < 8'hF0)
                            running = st;
                        cur = st;
                        if (st == ST_SYSEX || st == ST_ESCAPE)
                            restart(PH_SYSEX_LEN);
                        else if (st == ST_META)
                            phase = PH_META_TYPE;
                        else
                        begin
                            plen = 28'(short_msg_bytes(st));
                            remain = plen;
                            cap[0] = '0;
                            cap[1] = '0;
                            if (!b[7])
                            begin
                                cap[0] = b;
                                remain--;
                            end
                            if (remain == 0)
                                done = close_short(last, r);
                            else
                                phase = PH_CHAN_DATA;
                        end
                    end
                end
                PH_CHAN_DATA:
                begin
                    idx = int'(plen - remain) & 1;
                    cap[idx] = b;
                    remain--;
                    if (remain == 0)
                        done = close_short(last, r);
                end
                PH_SYSEX_LEN:
                begin
                    q = take_quantity(b);
                    if (q < 0)
                        fail = 1'b1;
                    else if (q > 0)
                    begin
                        plen = acc;
                        remain = acc;
                        last_pb = '0;
                        if (remain == 0)
                        begin
                            done = close_sysex(last, r);
                            fail = !done;
                        end
                        else
                            phase = PH_SYSEX_DATA;
                    end
                end
                PH_SYSEX_DATA:
                begin
                    last_pb = b;
                    remain--;
                    if (remain == 0)
                    begin
                        done = close_sysex(last, r);
                        fail = !done;
                    end
                end
                PH_META_TYPE:
                begin
                    mtype = b;
                    restart(PH_META_LEN);
                end
                PH_META_LEN:
                begin
                    q = take_quantity(b);
                    if (q < 0)
                        fail = 1'b1;
                    else if (q > 0)
                    begin
                        plen = acc;
                        remain = acc;
                        if (remain == 0)
                        begin
                            done = close_meta(last, r);
                            fail = !done;
                        end
                        else
                            phase = PH_META_DATA;
                    end
                end
                PH_META_DATA:
                begin
                    idx = int'(plen - remain);
                    if (idx < CAPTURE_LEN)
                        cap[idx] = b;
                    remain--;
                    if (remain == 0)
                    begin
                        done = close_meta(last, r);
                        fail = !done;
                    end
                end
                default: fail = 1'b1;
            endcase
            // A track that ends inside an event or a quantity is an error.
            if (!fail && !done && last && phase != PH_STATUS
                && !(phase == PH_DELTA && qcount == 0))
                fail = 1'b1;
            if (fail)
            begin
                err_latched = 1'b1;
                expected_q.push_back(make_result(KIND_ERROR, 4'd0, 7'd0, 14'd0, last));
            end
            else if (done)
                expected_q.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        // Compare one event beat with the oldest expected event.
        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report("event beat with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("channel", got.channel, want.channel);
            compare_field("first_data", got.first_data, want.first_data);
            compare_field("second_value", got.second_value, want.second_value);
            compare_field("tempo_us", got.tempo_us, want.tempo_us);
            compare_field("beats_per_bar", got.beats_per_bar, want.beats_per_bar);
            compare_field("beat_unit_log2", got.beat_unit_log2, want.beat_unit_log2);
            compare_field("event_tick", got.event_tick, want.event_tick);
            compare_field("track_end", got.track_end, want.track_end);
        endtask
    endclass

    track_scoreboard sb = new();

    logic [7:0] track_bytes [$];
    logic [7:0] running_st = '0;
    bit         have_running = 1'b0;

    midi_file_track_event_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #1 clk = ~clk;

    // Receiver backpressure.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Event beat monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(result_t'(m_axis_tdata[101:0]));
    end

    // Run time limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_midi_file_track_event_parser: done, errors");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(b);
    endtask

    task automatic send_track_bytes();
        while (track_bytes.size() != 0)
            send_byte(track_bytes.pop_front());
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write the track length once the parser has gone quiet.
    task automatic write_track_length(logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.track_length = v;
    endtask

    // Quantity in n bytes, padded with leading continuation bytes as needed.
    task automatic add_quantity(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            track_bytes.push_back(8'(((v >> (7 * i)) & 32'h7F) | (i != 0 ? 32'h80 : 32'h00)));
    endtask

    task automatic add_delta();
        int n;
        n = ($urandom_range(99) < 20) ? $urandom_range(2, 4) : 1;
        add_quantity($urandom & ((32'd1 << (7 * n)) - 1), n);
    endtask

    task automatic add_random(int n);
        repeat (n) track_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // One well-formed event with random content.
    task automatic add_event(int sel);
        logic [7:0] st;
        logic [7:0] sys_codes [13];
        logic [7:0] meta_types [6];
        int meta_lens [6];
        int len;
        int k;
        sys_codes = '{8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF8, 8'hF9, 8'hFA,
                      8'hFB, 8'hFC, 8'hFD, 8'hFE};
        meta_types = '{META_SEQ, META_CHPFX, META_TEMPO, META_SMPTE, META_TSIG, META_KSIG};
        meta_lens = '{2, 1, 3, 5, 4, 2};
        if (sel == 1 && !have_running)
            sel = 0;
        case (sel)
            0:
            begin
                st = 8'($urandom_range(8'h80, 8'hEF));
                running_st = st;
                have_running = 1'b1;
                track_bytes.push_back(st);
                add_random(short_msg_bytes(st));
            end
            1:
            begin
                track_bytes.push_back(8'($urandom_range(0, 127)));
                add_random(short_msg_bytes(running_st) - 1);
            end
            2:
            begin
                st = sys_codes[$urandom_range(0, 12)];
                track_bytes.push_back(st);
                add_random(short_msg_bytes(st));
            end
            3:
            begin
                len = $urandom_range(1, 16);
                track_bytes.push_back(ST_SYSEX);
                add_quantity(len, $urandom_range(1, 4));
                add_random(len - 1);
                track_bytes.push_back(ST_ESCAPE);
            end
            4:
            begin
                len = $urandom_range(0, 16);
                track_bytes.push_back(ST_ESCAPE);
                add_quantity(len, $urandom_range(1, 4));
                add_random(len);
            end
            5:
            begin
                k = $urandom_range(0, 5);
                track_bytes.push_back(ST_META);
                track_bytes.push_back(meta_types[k]);
                add_quantity(meta_lens[k], $urandom_range(1, 4));
                add_random(meta_lens[k]);
            end
            default:
            begin
                do
                    st = 8'($urandom_range(0, 255));
                while (st == META_SEQ || st == META_CHPFX || st == META_EOT || st == META_TEMPO
                       || st == META_SMPTE || st == META_TSIG || st == META_KSIG);
                len = $urandom_range(0, 12);
                track_bytes.push_back(ST_META);
                track_bytes.push_back(st);
                add_quantity(len, $urandom_range(1, 4));
                add_random(len);
            end
        endcase
    endtask

    task automatic run_random_block(int nbytes);
        int count;
        count = 0;
        while (count < nbytes)
        begin
            add_delta();
            add_event($urandom_range(0, 6));
            count += track_bytes.size();
            send_track_bytes();
        end
    endtask

    initial
    begin
        int err_sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero track length: every byte is dropped.
        write_track_length(32'd0);
        add_random(5);
        send_track_bytes();

        write_track_length(32'hFFFF_FFFF);
        tx_idle_pct = 21;
        rx_idle_pct = 45;

        // Directed events: every channel kind, data extremes, running status,
        // system messages, SysEx, escapes and each checked meta type but EOT.
        track_bytes = {8'h00, 8'h90, 8'h3C, 8'h7F,
                       8'h00, 8'h80, 8'hFF, 8'hFF,
                       8'h00, 8'hA5, 8'h00, 8'h00,
                       8'h00, 8'hBF, 8'h7F, 8'h7F,
                       8'h00, 8'hC3, 8'h80,
                       8'h00, 8'hDE, 8'h12,
                       8'h00, 8'hE0, 8'h00, 8'h40,
                       8'h00, 8'hEF, 8'h7F, 8'h7F,
                       8'h00, 8'h40, 8'h41,
                       8'h8F, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h3C, 8'h00,
                       8'h00, 8'hF2, 8'h01, 8'h02,
                       8'h00, 8'hF3, 8'h05,
                       8'h00, 8'hF1, 8'h00, 8'hF8, 8'h00, 8'hFE, 8'h00, 8'hF6,
                       8'h00, 8'hF0, 8'h03, 8'h11, 8'h22, 8'hF7,
                       8'h00, 8'hF7, 8'h00,
                       8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                       8'h00, 8'hFF, 8'h58, 8'h04, 8'h07, 8'hFF, 8'h18, 8'h08,
                       8'h00, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h01,
                       8'h00, 8'hFF, 8'h20, 8'h01, 8'h0F,
                       8'h00, 8'hFF, 8'h54, 8'h05, 8'h60, 8'h3B, 8'h3B, 8'h1D, 8'h63,
                       8'h00, 8'hFF, 8'h59, 8'h02, 8'hF9, 8'h01,
                       8'h00, 8'hFF, 8'h01, 8'h00,
                       8'h7F, 8'hFF, 8'h7F, 8'h06, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                       8'h80, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20};
        running_st = 8'hEF;
        have_running = 1'b1;
        send_track_bytes();

        // Random tracks under three idle patterns.
        run_random_block(390);
        tx_idle_pct = 45;
        rx_idle_pct = 21;
        run_random_block(390);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_block(390);

        // End of track landing exactly on the last byte, then dropped bytes.
        write_track_length(sb.consumed + 32'd4);
        track_bytes = {8'h00, ST_META, META_EOT, 8'h00};
        add_random(3);
        send_track_bytes();

        // A tail, mostly malformed; an error latches and the rest is dropped.
        tx_idle_pct = 21;
        rx_idle_pct = 45;
        err_sel = $urandom_range(0, 7);
        case (err_sel)
            0: track_bytes = {8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
            1: track_bytes = {8'h00, ST_SYSEX, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
            2: track_bytes = {8'h00, ST_SYSEX, 8'h00};
            3: track_bytes = {8'h00, ST_SYSEX, 8'h02, 8'h11, 8'h22};
            4: track_bytes = {8'h00, ST_META, META_TEMPO, 8'h02, 8'h11, 8'h22};
            5: track_bytes = {8'h00, ST_META, META_EOT, 8'h00};
            6: track_bytes = {8'h00, 8'h90, 8'h40};
            default: track_bytes = {8'h00};
        endcase
        if (err_sel >= 6)
            write_track_length(sb.consumed + track_bytes.size());
        else
            write_track_length(sb.consumed + 32'd64);
        add_random(8);
        send_track_bytes();

        s_axis_tvalid <= 1'b0;
        wait_drained();
        if (sb.errors == 0)
            $display("tb_midi_file_track_event_parser: done, clean");
        else
            $display("tb_midi_file_track_event_parser: done, errors");
        $finish;
    end

endmodule

### midi_file_track_event_parser.f
rtl/mftp_pkg.sv
rtl/mftp_front.sv
rtl/mftp_parser.sv
rtl/midi_file_track_event_parser.sv
verif/tb_midi_file_track_event_parser.sv
